// ===== hdl/cpt_pkg.sv =====
// shared constants, types and the quarter-wave sine table of the transform unit
`timescale 1ns / 1ps

package cpt_pkg;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int ANGLE_BITS       = 16;

    localparam int ANGLE_IN_W = 16;
    localparam int SAMPLE_W   = 16;
    localparam int OP_W       = 3;
    localparam int TRIG_W     = 16;
    localparam int ENTRY_W    = 15;
    localparam int QUAD_W     = ANGLE_BITS - 2;
    localparam int IDX_W      = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int SCALE_W    = SUM_W + 16;
    localparam int FRAC_SHIFT = 30;

    // one third of a turn, rounded to whole angle counts
    localparam logic [ANGLE_BITS-1:0] ANGLE_THIRD =
        ANGLE_BITS'(((64'd1 << ANGLE_BITS) + 64'd1) / 64'd3);
    localparam logic [ANGLE_BITS-1:0] ANGLE_QUARTER = ANGLE_BITS'(64'd1 << QUAD_W);

    // q1.15 constants
    localparam logic signed [TRIG_W-1:0] K_TWO_THIRDS     = 16'sd21845;
    localparam logic signed [TRIG_W-1:0] K_SQRT_2_3       = 16'sd26755;
    localparam logic signed [TRIG_W-1:0] K_SQRT_HALF      = 16'sd23170;
    localparam logic signed [TRIG_W-1:0] K_HALF_SQRT_2_3  = 16'sd13377;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [OP_W-1:0] {
        OP_ABC_AB  = 3'd0,
        OP_ABC_DQ  = 3'd1,
        OP_AB_ABC  = 3'd2,
        OP_AB_DQ   = 3'd3,
        OP_DQ_ABC  = 3'd4,
        OP_DQ_AB   = 3'd5
    } op_code_t;

    typedef logic [ENTRY_W-1:0] sine_table_t [0:SINE_TABLE_DEPTH];

    // entries worked out by an integer taylor series in q2.30
    function automatic sine_table_t build_sine_table();
        sine_table_t        tbl;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        e;
        logic signed [63:0] sum;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int k = 1; k <= 8; k++) begin
                term = (term * x2) >> 30;
                case (k)
                    1:       term = term / 64'd6;
                    2:       term = term / 64'd20;
                    3:       term = term / 64'd42;
                    4:       term = term / 64'd72;
                    5:       term = term / 64'd110;
                    6:       term = term / 64'd156;
                    7:       term = term / 64'd210;
                    default: term = term / 64'd272;
                endcase
                if (k % 2 == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            e = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
            tbl[i] = (e > 64'd32767) ? ENTRY_W'(32767) : e[ENTRY_W-1:0];
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

// ===== hdl/clarke_park_transform_unit.sv =====
// clarke / park coordinate transform unit, six-stage pipeline
`timescale 1ns / 1ps

// channel   dir   tdata (low bit up)                     tuser
// s_        in    in_x, in_y, in_z, angle (64 bits)      operation (3 bits)
// m_        out   out_x, out_y, out_z (48 bits)          -
//
// one item per cycle unless the output stalls
// stages: capture, sine/cosine table, coefficient multiply, sum, scale, round
// each stage holds its own valid bit and loads when the stage after it frees up,
// so a stalled output lets earlier stages fill and nothing is lost or repeated
// aresetn clears the valid bits only

module clarke_park_transform_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // in_x, in_y, in_z, angle
    input  logic [2:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // out_x, out_y, out_z
);

    localparam int SW = cpt_pkg::SAMPLE_W;
    localparam int TW = cpt_pkg::TRIG_W;

    // stage valids and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6     = !v6_reg || m_tready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    // stage 1: capture
    logic [cpt_pkg::OP_W-1:0]       op1_reg;
    logic signed [SW-1:0]           x1_reg, y1_reg, z1_reg;
    logic [cpt_pkg::ANGLE_BITS-1:0] ang1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            op1_reg  <= s_tuser;
            x1_reg   <= s_tdata[15:0];
            y1_reg   <= s_tdata[31:16];
            z1_reg   <= s_tdata[47:32];
            ang1_reg <= cpt_pkg::ANGLE_BITS'(s_tdata[48 +: cpt_pkg::ANGLE_IN_W]);
        end
    end

    // stage 2: sine and cosine at t, t minus a third and t plus a third
    logic [cpt_pkg::ANGLE_BITS-1:0] ang_m, ang_p;
    logic signed [TW-1:0] sin0_next, cos0_next, sinm_next, cosm_next, sinp_next, cosp_next;

    assign ang_m = ang1_reg - cpt_pkg::ANGLE_THIRD;
    assign ang_p = ang1_reg + cpt_pkg::ANGLE_THIRD;

    cpt_sincos u_trig_0 (.angle(ang1_reg), .sin_val(sin0_next), .cos_val(cos0_next));
    cpt_sincos u_trig_m (.angle(ang_m),    .sin_val(sinm_next), .cos_val(cosm_next));
    cpt_sincos u_trig_p (.angle(ang_p),    .sin_val(sinp_next), .cos_val(cosp_next));

    logic [cpt_pkg::OP_W-1:0] op2_reg;
    logic signed [SW-1:0]     x2_reg, y2_reg, z2_reg;
    logic signed [TW-1:0]     sin0_reg, cos0_reg, sinm_reg, cosm_reg, sinp_reg, cosp_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            op2_reg  <= op1_reg;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            z2_reg   <= z1_reg;
            sin0_reg <= sin0_next;
            cos0_reg <= cos0_next;
            sinm_reg <= sinm_next;
            cosm_reg <= cosm_next;
            sinp_reg <= sinp_next;
            cosp_reg <= cosp_next;
        end
    end

    // stage 3: pick coefficients per output row and multiply
    logic signed [TW-1:0]              coef [0:2][0:2];
    logic signed [SW-1:0]              operand [0:2];
    logic signed [cpt_pkg::PROD_W-1:0] prod_next [0:2][0:2];
    logic signed [cpt_pkg::PROD_W-1:0] prod_reg [0:2][0:2];
    logic [cpt_pkg::OP_W-1:0]          op3_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef[r][c] = '0;
            end
        end
        case (op2_reg)
            cpt_pkg::OP_ABC_AB: begin
                coef[0][0] = cpt_pkg::K_SQRT_2_3;
                coef[0][1] = -cpt_pkg::K_HALF_SQRT_2_3;
                coef[0][2] = -cpt_pkg::K_HALF_SQRT_2_3;
                coef[1][1] = cpt_pkg::K_SQRT_HALF;
                coef[1][2] = -cpt_pkg::K_SQRT_HALF;
            end
            cpt_pkg::OP_ABC_DQ: begin
                coef[0][0] = cos0_reg;
                coef[0][1] = cosm_reg;
                coef[0][2] = cosp_reg;
                coef[1][0] = -sin0_reg;
                coef[1][1] = -sinm_reg;
                coef[1][2] = -sinp_reg;
            end
            cpt_pkg::OP_AB_ABC: begin
                coef[0][0] = cpt_pkg::K_SQRT_2_3;
                coef[1][0] = -cpt_pkg::K_HALF_SQRT_2_3;
                coef[1][1] = cpt_pkg::K_SQRT_HALF;
                coef[2][0] = -cpt_pkg::K_HALF_SQRT_2_3;
                coef[2][1] = -cpt_pkg::K_SQRT_HALF;
            end
            cpt_pkg::OP_AB_DQ: begin
                coef[0][0] = cos0_reg;
                coef[0][1] = sin0_reg;
                coef[1][0] = -sin0_reg;
                coef[1][1] = cos0_reg;
            end
            cpt_pkg::OP_DQ_ABC: begin
                coef[0][0] = cos0_reg;
                coef[0][1] = -sin0_reg;
                coef[1][0] = cosm_reg;
                coef[1][1] = -sinm_reg;
                coef[2][0] = cosp_reg;
                coef[2][1] = -sinp_reg;
            end
            cpt_pkg::OP_DQ_AB: begin
                coef[0][0] = cos0_reg;
                coef[0][1] = -sin0_reg;
                coef[1][0] = sin0_reg;
                coef[1][1] = cos0_reg;
            end
            default: begin
                // unused codes leave every coefficient at zero
            end
        endcase
    end

    assign operand[0] = x2_reg;
    assign operand[1] = y2_reg;
    assign operand[2] = z2_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[r][c] = cpt_pkg::PROD_W'(coef[r][c]) *
                                  cpt_pkg::PROD_W'(operand[c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            op3_reg  <= op2_reg;
            prod_reg <= prod_next;
        end
    end

    // stage 4: sum each row
    logic signed [cpt_pkg::SUM_W-1:0] sum_next [0:2];
    logic signed [cpt_pkg::SUM_W-1:0] sum_reg [0:2];
    logic [cpt_pkg::OP_W-1:0]         op4_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum_next[r] = cpt_pkg::SUM_W'(prod_reg[r][0]) + cpt_pkg::SUM_W'(prod_reg[r][1]) +
                          cpt_pkg::SUM_W'(prod_reg[r][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            op4_reg <= op3_reg;
            sum_reg <= sum_next;
        end
    end

    // stage 5: bring every row to q2.30 weight, abc->dq takes the 2/3 factor here
    logic signed [cpt_pkg::SCALE_W-1:0] scale_next [0:2];
    logic signed [cpt_pkg::SCALE_W-1:0] scale_reg [0:2];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (op4_reg == cpt_pkg::OP_ABC_DQ) begin
                scale_next[r] = cpt_pkg::SCALE_W'(sum_reg[r]) *
                                cpt_pkg::SCALE_W'(cpt_pkg::K_TWO_THIRDS);
            end else begin
                scale_next[r] = cpt_pkg::SCALE_W'(sum_reg[r]) <<< 15;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            scale_reg <= scale_next;
        end
    end

    // stage 6: round half up and saturate
    localparam int RQ_W = cpt_pkg::SCALE_W - cpt_pkg::FRAC_SHIFT;

    logic signed [cpt_pkg::SCALE_W-1:0] rsum [0:2];
    logic signed [RQ_W-1:0]             rq [0:2];
    logic signed [SW-1:0]               out_next [0:2];
    logic [47:0]                        tdata_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            rsum[r] = scale_reg[r] +
                      (cpt_pkg::SCALE_W'(1) <<< (cpt_pkg::FRAC_SHIFT - 1));
            rq[r]   = rsum[r][cpt_pkg::SCALE_W-1:cpt_pkg::FRAC_SHIFT];
            if (rq[r] > RQ_W'(32767)) begin
                out_next[r] = 16'sh7fff;
            end else if (rq[r] < -RQ_W'(32768)) begin
                out_next[r] = 16'sh8000;
            end else begin
                out_next[r] = rq[r][SW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy6) begin
            tdata_reg <= {out_next[2], out_next[1], out_next[0]};
        end
    end

    assign m_tdata = tdata_reg;

endmodule

// ===== hdl/cpt_sincos.sv =====
// sine and cosine of one angle from the quarter-wave table
`timescale 1ns / 1ps

module cpt_sincos (
    input  logic [cpt_pkg::ANGLE_BITS-1:0]     angle,
    output logic signed [cpt_pkg::TRIG_W-1:0]  sin_val,
    output logic signed [cpt_pkg::TRIG_W-1:0]  cos_val
);

    localparam int MUL_W = cpt_pkg::QUAD_W + cpt_pkg::IDX_W;

    function automatic logic signed [cpt_pkg::TRIG_W-1:0] sine_lookup(
        input logic [cpt_pkg::ANGLE_BITS-1:0] ang
    );
        logic [1:0]                     quad;
        logic [cpt_pkg::QUAD_W-1:0]     pos;
        logic [MUL_W-1:0]               scaled;
        logic [cpt_pkg::IDX_W-1:0]      idx;
        logic [cpt_pkg::ENTRY_W-1:0]    mag;
        quad   = ang[cpt_pkg::ANGLE_BITS-1 -: 2];
        pos    = ang[cpt_pkg::QUAD_W-1:0];
        scaled = MUL_W'(pos) * MUL_W'(cpt_pkg::SINE_TABLE_DEPTH);
        idx    = cpt_pkg::IDX_W'(scaled >> cpt_pkg::QUAD_W);
        // odd quadrants run the table backwards
        if (quad[0]) begin
            idx = cpt_pkg::IDX_W'(cpt_pkg::SINE_TABLE_DEPTH) - idx;
        end
        mag = cpt_pkg::SINE_TABLE[idx];
        if (quad[1]) begin
            return -$signed({1'b0, mag});
        end
        return $signed({1'b0, mag});
    endfunction

    always_comb begin
        sin_val = sine_lookup(angle);
        cos_val = sine_lookup(angle + cpt_pkg::ANGLE_QUARTER);
    end

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the clarke / park transform unit
`timescale 1ns / 1ps

module testbench;

    // codes that the block does not define, expected to give all zeros
    localparam logic [2:0] OP_RESERVED_LO = 3'd6;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;

    localparam longint Q15_TWO_THIRDS     = 21845;
    localparam longint Q15_SQRT_2_3       = 26755;
    localparam longint Q15_SQRT_HALF      = 23170;
    localparam longint Q15_HALF_SQRT_2_3  = 13377;
    localparam int     THIRD_TURN         = ((1 << cpt_pkg::ANGLE_BITS) + 1) / 3;
    localparam int     QUARTER_TURN       = 1 << (cpt_pkg::ANGLE_BITS - 2);
    localparam int     PIPE_DEPTH         = 6;
    localparam int     SETTLE_CYCLES      = 2 * PIPE_DEPTH + 4;
    localparam int     MAX_PRINTED        = 25;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } coord_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // in_x, in_y, in_z, angle
    logic [2:0]  s_tuser  = '0;   // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // out_x, out_y, out_z

    longint sine_q15 [0:cpt_pkg::SINE_TABLE_DEPTH];
    coord_t expected_coords [$];
    bit     idle_en = 1'b1;
    int     rx_hold_cycles = 0;
    int     items_sent = 0;
    int     results_checked = 0;
    int     input_stall_cycles = 0;
    int     error_count = 0;
    int     op_seen [8];

    clarke_park_transform_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // quarter-wave table, integer taylor series in q2.30 scaled to q1.15
    initial begin : build_sine
        logic [63:0] ang_q30;
        logic [63:0] ang_sq;
        logic [63:0] term;
        longint      acc;
        longint      entry;
        for (int i = 0; i <= cpt_pkg::SINE_TABLE_DEPTH; i++) begin
            ang_q30 = (64'd1686629713 * 64'(i)) / 64'(cpt_pkg::SINE_TABLE_DEPTH);
            ang_sq  = (ang_q30 * ang_q30) >> 30;
            term    = ang_q30;
            acc     = longint'(ang_q30);
            for (int k = 1; k <= 8; k++) begin
                term = ((term * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            entry = (acc * 32767 + (longint'(1) << 29)) >>> 30;
            sine_q15[i] = (entry > 32767) ? 32767 : entry;
        end
    end

    function automatic longint sine_lookup(input int unsigned ang);
        int unsigned a;
        int unsigned quad;
        longint      pos;
        int unsigned idx;
        longint      v;
        a    = ang & ((1 << cpt_pkg::ANGLE_BITS) - 1);
        quad = (a >> (cpt_pkg::ANGLE_BITS - 2)) & 3;
        pos  = a & (QUARTER_TURN - 1);
        idx  = (pos * cpt_pkg::SINE_TABLE_DEPTH) >> (cpt_pkg::ANGLE_BITS - 2);
        v    = quad[0] ? sine_q15[cpt_pkg::SINE_TABLE_DEPTH - idx] : sine_q15[idx];
        return quad[1] ? -v : v;
    endfunction

    function automatic longint cosine_lookup(input int unsigned ang);
        return sine_lookup(ang + QUARTER_TURN);
    endfunction

    // round half up: floor(v / 2^s + 1/2)
    function automatic longint round_q(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] sat16(input longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    function automatic coord_t predict_transform(input logic [2:0] op,
                                                 input logic signed [15:0] xi,
                                                 input logic signed [15:0] yi,
                                                 input logic signed [15:0] zi,
                                                 input logic [15:0] ang);
        longint      x;
        longint      y;
        longint      z;
        longint      rx;
        longint      ry;
        longint      rz;
        longint      sd;
        longint      sq;
        longint      c;
        longint      s;
        int unsigned a0;
        int unsigned am;
        int unsigned ap;
        coord_t      res;
        x  = xi;
        y  = yi;
        z  = zi;
        rx = 0;
        ry = 0;
        rz = 0;
        a0 = ang;
        am = a0 - THIRD_TURN;
        ap = a0 + THIRD_TURN;
        c  = cosine_lookup(a0);
        s  = sine_lookup(a0);
        case (op)
            cpt_pkg::OP_ABC_AB: begin
                rx = round_q(Q15_SQRT_2_3 * x - Q15_HALF_SQRT_2_3 * y
                             - Q15_HALF_SQRT_2_3 * z, 15);
                ry = round_q(Q15_SQRT_HALF * y - Q15_SQRT_HALF * z, 15);
            end
            cpt_pkg::OP_ABC_DQ: begin
                // q keeps the standard sign on the c term
                sd = c * x + cosine_lookup(am) * y + cosine_lookup(ap) * z;
                sq = s * x + sine_lookup(am) * y + sine_lookup(ap) * z;
                rx = round_q(sd * Q15_TWO_THIRDS, 30);
                ry = round_q(-sq * Q15_TWO_THIRDS, 30);
            end
            cpt_pkg::OP_AB_ABC: begin
                rx = round_q(Q15_SQRT_2_3 * x, 15);
                ry = round_q(-Q15_HALF_SQRT_2_3 * x + Q15_SQRT_HALF * y, 15);
                rz = round_q(-Q15_HALF_SQRT_2_3 * x - Q15_SQRT_HALF * y, 15);
            end
            cpt_pkg::OP_AB_DQ: begin
                rx = round_q(c * x + s * y, 15);
                ry = round_q(-s * x + c * y, 15);
            end
            cpt_pkg::OP_DQ_ABC: begin
                rx = round_q(c * x - s * y, 15);
                ry = round_q(cosine_lookup(am) * x - sine_lookup(am) * y, 15);
                rz = round_q(cosine_lookup(ap) * x - sine_lookup(ap) * y, 15);
            end
            cpt_pkg::OP_DQ_AB: begin
                rx = round_q(c * x - s * y, 15);
                ry = round_q(s * x + c * y, 15);
            end
            default: begin
            end
        endcase
        res.x = sat16(rx);
        res.y = sat16(ry);
        res.z = sat16(rz);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        if (error_count < MAX_PRINTED) begin
            $display("%0t ns mismatch on %s: expected %0d, got %0d",
                     $time, what, want_v, got_v);
        end
        error_count++;
    endtask

    task automatic check_result(input logic [47:0] beat);
        coord_t want;
        coord_t got;
        got = beat;
        if (expected_coords.size() == 0) begin
            report_mismatch("unexpected result out_x", 0, got.x);
            return;
        end
        want = expected_coords.pop_front();
        if (got.x !== want.x) report_mismatch("out_x", want.x, got.x);
        if (got.y !== want.y) report_mismatch("out_y", want.y, got.y);
        if (got.z !== want.z) report_mismatch("out_z", want.z, got.z);
        results_checked++;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
            end
            if (s_tvalid && !s_tready) begin
                input_stall_cycles++;
            end
        end
    end

    // result side: random stalls, or one long hold-off when asked for
    initial begin : sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = idle_en ? $urandom_range(0, 8) : 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1 && rx_hold_cycles == 0);
        end
    end

    task automatic send_item(input logic [2:0] op, input logic [15:0] xi,
                             input logic [15:0] yi, input logic [15:0] zi,
                             input logic [15:0] ang);
        int gap;
        gap = idle_en ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ang, zi, yi, xi};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        expected_coords.push_back(predict_transform(op, xi, yi, zi, ang));
        items_sent++;
        op_seen[op]++;
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (expected_coords.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(0, 8191)) - 16'd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 11))
            0:       return 16'(QUARTER_TURN * $urandom_range(0, 3));
            1:       return 16'(QUARTER_TURN * $urandom_range(0, 3) - 1);
            2:       return 16'(THIRD_TURN * $urandom_range(1, 2));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [2:0] rand_op();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(0, 1) ? OP_RESERVED_HI : OP_RESERVED_LO;
        end
        return 3'($urandom_range(0, 5));
    endfunction

    task automatic test_directed_corners();
        send_item(cpt_pkg::OP_ABC_AB, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000);
        send_item(cpt_pkg::OP_ABC_AB, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_item(cpt_pkg::OP_ABC_DQ, 16'h1000, 16'hF800, 16'hF800, 16'h0000);
        send_item(cpt_pkg::OP_ABC_DQ, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_item(cpt_pkg::OP_ABC_DQ, 16'h1000, 16'h0000, 16'h1000, 16'(THIRD_TURN));
        send_item(cpt_pkg::OP_ABC_DQ, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
        // c is ignored by the two-axis inputs
        send_item(cpt_pkg::OP_AB_ABC, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h1234);
        send_item(cpt_pkg::OP_AB_ABC, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000);
        send_item(cpt_pkg::OP_AB_DQ,  16'h7FFF, 16'h8000, 16'h5555, 16'h4000);
        send_item(cpt_pkg::OP_AB_DQ,  16'h2000, 16'hE000, 16'h0000, 16'h8000);
        send_item(cpt_pkg::OP_AB_DQ,  16'h7FFF, 16'h7FFF, 16'h8000, 16'h2000);
        send_item(cpt_pkg::OP_DQ_ABC, 16'h8000, 16'h7FFF, 16'h3039, 16'hC000);
        send_item(cpt_pkg::OP_DQ_ABC, 16'h1000, 16'h0000, 16'h0000, 16'h0000);
        send_item(cpt_pkg::OP_DQ_AB,  16'h7FFF, 16'h7FFF, 16'hAAAA, 16'hFFFF);
        send_item(cpt_pkg::OP_DQ_AB,  16'h8000, 16'h8000, 16'h0000, 16'h6000);
        send_item(OP_RESERVED_LO, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_item(OP_RESERVED_HI, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
        wait_for_drain();
    endtask

    task automatic test_random_mix();
        for (int blk = 0; blk < 10; blk++) begin
            // every fourth block runs with no gaps on either side
            idle_en = (blk % 4 != 3);
            for (int n = 0; n < 100; n++) begin
                send_item(rand_op(), rand_sample(), rand_sample(), rand_sample(),
                          rand_angle());
            end
            wait_for_drain();
        end
        idle_en = 1'b1;
    endtask

    task automatic test_back_to_back();
        idle_en = 1'b0;
        for (int n = 0; n < 120; n++) begin
            send_item(rand_op(), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
        end
        idle_en = 1'b1;
        wait_for_drain();
    endtask

    task automatic test_output_stall();
        // long hold on the result side while items keep coming, so the pipe fills
        rx_hold_cycles = 80;
        idle_en = 1'b0;
        for (int n = 0; n < 48; n++) begin
            send_item(rand_op(), rand_sample(), rand_sample(), rand_sample(),
                      rand_angle());
        end
        idle_en = 1'b1;
        wait_for_drain();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_corners();
        test_random_mix();
        test_back_to_back();
        test_output_stall();

        $display("%0d sent, %0d checked; per operation code 0-7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 items_sent, results_checked, op_seen[0], op_seen[1], op_seen[2],
                 op_seen[3], op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
        $display("input held off for %0d cycles by output back-pressure, %0d mismatches",
                 input_stall_cycles, error_count);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
